// File: rtl/assert_macros.svh
// assertion macros shared by the rc4 rtl
// no dependencies; included by files that carry concurrent assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every rising clock edge outside reset
`define ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// plain invariant checked on every rising clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

`endif

// File: rtl/rc4_pkg.sv
// rc4 package: constants, microcode word layout and the microcode rom
// no dependencies; used by every other rc4 file except rc4_chan_if
`timescale 1ns / 1ps

package rc4_pkg;

   localparam int BYTE_W         = 8;
   localparam int TABLE_SIZE     = 256;
   localparam int KEY_BYTES_DFLT = 256;
   localparam int UPC_W          = 4;

   // microcode addresses
   localparam logic [UPC_W-1:0] UA_IDLE = 4'd0;
   localparam logic [UPC_W-1:0] UA_D0   = 4'd1;
   localparam logic [UPC_W-1:0] UA_D1   = 4'd2;
   localparam logic [UPC_W-1:0] UA_D2   = 4'd3;
   localparam logic [UPC_W-1:0] UA_KS   = 4'd4;
   localparam logic [UPC_W-1:0] UA_K0   = 4'd5;
   localparam logic [UPC_W-1:0] UA_K1   = 4'd6;
   localparam logic [UPC_W-1:0] UA_K2   = 4'd7;
   localparam logic [UPC_W-1:0] UA_K3   = 4'd8;
   localparam logic [UPC_W-1:0] UA_K4   = 4'd9;

   // read port 0 address select
   localparam logic [1:0] RD0_NONE  = 2'd0;
   localparam logic [1:0] RD0_INEXT = 2'd1;
   localparam logic [1:0] RD0_ICUR  = 2'd2;
   localparam logic [1:0] RD0_SUM   = 2'd3;

   // j update, also the read port 1 address
   localparam logic [1:0] JADD_NONE    = 2'd0;
   localparam logic [1:0] JADD_RD0     = 2'd1;
   localparam logic [1:0] JADD_RD0_KEY = 2'd2;

   // i update
   localparam logic [1:0] IOP_HOLD = 2'd0;
   localparam logic [1:0] IOP_INC  = 2'd1;
   localparam logic [1:0] IOP_CLR  = 2'd2;

   // write port select
   localparam logic [1:0] WR_NONE  = 2'd0;
   localparam logic [1:0] WR_I_RD1 = 2'd1;
   localparam logic [1:0] WR_J_SV  = 2'd2;

   // branch kinds
   localparam logic [1:0] BR_NEXT = 2'd0;
   localparam logic [1:0] BR_LOOP = 2'd1;
   localparam logic [1:0] BR_END  = 2'd2;

   typedef struct packed {
      logic [1:0]       rd0_sel;
      logic [1:0]       jadd;
      logic             j_clr;
      logic [1:0]       i_op;
      logic [1:0]       wr_sel;
      logic             key_rd;
      logic             key_clr;
      logic             key_adv;
      logic             clr_valid;
      logic             save;
      logic             arm_fin;
      logic             set_done;
      logic [1:0]       br;
      logic [UPC_W-1:0] target;
   } ucode_type;

   typedef struct packed {
      logic data;
      logic key;
      logic last;
   } accept_type;

   function automatic ucode_type ucode_rom(input logic [UPC_W-1:0] addr);
      ucode_type w;
      w    = '0;
      w.br = BR_END;
      case (addr)
         UA_IDLE: begin
            w.br = BR_END;
         end
         // prga: i += 1, read s[i]
         UA_D0: begin
            w.rd0_sel = RD0_INEXT;
            w.i_op    = IOP_INC;
            w.br      = BR_NEXT;
         end
         // j += s[i], read s[j]
         UA_D1: begin
            w.jadd = JADD_RD0;
            w.br   = BR_NEXT;
         end
         // s[i] <= s[j], read s[s[i]+s[j]], arm the deferred s[j] write
         UA_D2: begin
            w.wr_sel  = WR_I_RD1;
            w.rd0_sel = RD0_SUM;
            w.save    = 1'b1;
            w.arm_fin = 1'b1;
            w.br      = BR_END;
         end
         // key schedule start: identity table, indices and key pointer cleared
         UA_KS: begin
            w.i_op      = IOP_CLR;
            w.j_clr     = 1'b1;
            w.key_clr   = 1'b1;
            w.clr_valid = 1'b1;
            w.br        = BR_NEXT;
         end
         UA_K0: begin
            w.rd0_sel = RD0_ICUR;
            w.key_rd  = 1'b1;
            w.br      = BR_NEXT;
         end
         UA_K1: begin
            w.jadd = JADD_RD0_KEY;
            w.br   = BR_NEXT;
         end
         UA_K2: begin
            w.wr_sel = WR_I_RD1;
            w.save   = 1'b1;
            w.br     = BR_NEXT;
         end
         UA_K3: begin
            w.wr_sel  = WR_J_SV;
            w.i_op    = IOP_INC;
            w.key_adv = 1'b1;
            w.br      = BR_LOOP;
            w.target  = UA_K0;
         end
         UA_K4: begin
            w.j_clr    = 1'b1;
            w.set_done = 1'b1;
            w.br       = BR_END;
         end
         default: begin
            w.br = BR_END;
         end
      endcase
      return w;
   endfunction

endpackage

// File: rtl/rc4_chan_if.sv
// request and response channel interfaces of the rc4 engine
// valid/ready handshake with the item payload; no dependencies
`timescale 1ns / 1ps

interface rc4_req_if;
   logic       valid;
   logic       ready;
   logic       kind;
   logic [7:0] byte_in;
   logic       key_last;

   modport source (output valid, output kind, output byte_in, output key_last, input ready);
   modport sink (input valid, input kind, input byte_in, input key_last, output ready);
endinterface

interface rc4_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] byte_out;

   modport source (output valid, output byte_out, input ready);
   modport sink (input valid, input byte_out, output ready);
endinterface

// File: rtl/rc4_stream_cipher.sv
// rc4 stream cipher top level: handshake, output register, sequencer and datapath
// depends on rc4_pkg, rc4_chan_if, rc4_useq, rc4_datapath and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

// usage
// - req_chan carries one transaction per byte: kind 0 is a key byte, kind 1 a data byte;
//   key_last on a key byte starts the key schedule
// - rsp_chan carries byte_out = data byte xor keystream, one per data byte, in order;
//   key bytes give nothing back
// - a plain key byte is only written into the key store
// - a data byte runs steps d0 to d2: dependent reads of s[i], s[j] and the keystream
//   byte and the first swap write; the second swap write waits for an idle write slot;
//   its result enters the output register toward rsp_chan together with that write
// - a flagged key byte runs the schedule: a setup step, steps k0 to k3 for each of the
//   256 swaps and a closing step, all on the single permutation ram write port;
//   req_chan.ready stays low meanwhile
// - reset (synchronous, active high) gives the identity permutation and zero indices
//   through per-entry valid flops, so no clearing pass runs; a stored key is forgotten
// - when rsp_chan stalls, one finished result waits in the output register and the next
//   transaction is still taken; a further result holds req_chan.ready low until the
//   waiting one is taken

module rc4_stream_cipher import rc4_pkg::*; #(
   parameter int MAX_KEY_BYTES = KEY_BYTES_DFLT
) (
   input logic        clock,
   input logic        reset,
   rc4_req_if.sink    req_chan,
   rc4_rsp_if.source  rsp_chan
);

   accept_type        acc;
   ucode_type         ctrl;
   logic              seq_idle;
   logic              i_last;
   logic              fin_pend;
   logic              out_load;
   logic [BYTE_W-1:0] out_byte;
   logic              out_free;
   logic              take;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0] rsp_byte_ff, rsp_byte_in;

   // output register can take a new result this cycle
   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   // take a transaction only between programs, and only if a pending result can drain
   assign req_chan.ready = seq_idle && (!fin_pend || out_free);
   assign take           = req_chan.valid && req_chan.ready;

   assign acc.data = take && req_chan.kind;
   assign acc.key  = take && !req_chan.kind;
   assign acc.last = req_chan.key_last;

   rc4_useq u_useq (
      .clock    (clock),
      .reset    (reset),
      .acc      (acc),
      .i_last   (i_last),
      .ctrl     (ctrl),
      .seq_idle (seq_idle)
   );

   rc4_datapath #(
      .MAX_KEY_BYTES (MAX_KEY_BYTES)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (ctrl),
      .acc      (acc),
      .byte_in  (req_chan.byte_in),
      .out_free (out_free),
      .i_last   (i_last),
      .fin_pend (fin_pend),
      .out_load (out_load),
      .out_byte (out_byte)
   );

   // result register toward rsp_chan
   always_comb begin
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_byte_in = out_load ? out_byte : rsp_byte_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_byte_ff <= rsp_byte_in;
   end

   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.byte_out = rsp_byte_ff;

   `ASSERT_IMPL(a_no_overwrite, clock, reset, out_load, out_free, "result register overwritten")

endmodule

// File: rtl/rc4_useq.sv
// rc4 microcode sequencer: step counter, rom lookup and branch resolution
// depends on rc4_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rc4_useq import rc4_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  accept_type acc,
   input  logic       i_last,
   output ucode_type  ctrl,
   output logic       seq_idle
);

   logic [UPC_W-1:0] upc_ff;
   logic [UPC_W-1:0] upc_in;
   logic [UPC_W-1:0] cur_addr;

   assign seq_idle = (upc_ff == UA_IDLE);

   // entry words run in the cycle the transaction is taken
   always_comb begin
      if (seq_idle) begin
         if (acc.data) begin
            cur_addr = UA_D0;
         end else if (acc.key && acc.last) begin
            cur_addr = UA_KS;
         end else begin
            cur_addr = UA_IDLE;
         end
      end else begin
         cur_addr = upc_ff;
      end
   end

   assign ctrl = ucode_rom(cur_addr);

   always_comb begin
      case (ctrl.br)
         BR_NEXT: upc_in = cur_addr + UPC_W'(1);
         BR_LOOP: upc_in = i_last ? cur_addr + UPC_W'(1) : ctrl.target;
         BR_END:  upc_in = UA_IDLE;
         default: upc_in = UA_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff <= UA_IDLE;
      end else begin
         upc_ff <= upc_in;
      end
   end

   `ASSERT_ALWAYS(a_upc_range, clock, reset, upc_ff <= UA_K4, "step counter left the program")

endmodule

// File: rtl/rc4_datapath.sv
// rc4 datapath: permutation ram, key store, i/j indices and deferred swap write
// depends on rc4_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rc4_datapath import rc4_pkg::*; #(
   parameter int MAX_KEY_BYTES = KEY_BYTES_DFLT
) (
   input  logic              clock,
   input  logic              reset,
   input  ucode_type         ctrl,
   input  accept_type        acc,
   input  logic [BYTE_W-1:0] byte_in,
   input  logic              out_free,
   output logic              i_last,
   output logic              fin_pend,
   output logic              out_load,
   output logic [BYTE_W-1:0] out_byte
);

   localparam int LEN_W  = $clog2(MAX_KEY_BYTES + 1);
   localparam int KEY_AW = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;

   logic [BYTE_W-1:0] perm_mem [TABLE_SIZE];
   logic [BYTE_W-1:0] key_mem [MAX_KEY_BYTES];

   logic [TABLE_SIZE-1:0] valid_ff, valid_in;
   logic [BYTE_W-1:0]     i_ff, i_in;
   logic [BYTE_W-1:0]     j_ff, j_in;
   logic [BYTE_W-1:0]     sv_ff, sv_in;
   logic [BYTE_W-1:0]     din_ff, din_in;
   logic [BYTE_W-1:0]     rd0_ff, rd1_ff, krd_ff;
   logic [LEN_W-1:0]      len_ff, len_in;
   logic [LEN_W-1:0]      kidx_ff, kidx_in;
   logic                  done_ff, done_in;
   logic                  fin_ff, fin_in;

   logic [BYTE_W-1:0] j_sum;
   logic [BYTE_W-1:0] rd0_addr;
   logic              rd0_en, rd1_en;
   logic              we;
   logic [BYTE_W-1:0] waddr, wdata;
   logic              fin_go;
   logic [LEN_W-1:0]  eff_len;
   logic              key_room;
   logic              key_we;
   logic [LEN_W-1:0]  kidx_nxt;
   logic [BYTE_W-1:0] t_addr;
   logic [BYTE_W-1:0] ks_byte;

   assign fin_go   = fin_ff && out_free;
   assign fin_pend = fin_ff;
   assign i_last   = (i_ff == {BYTE_W{1'b1}});

   // j + s[i], plus the key byte during the schedule
   assign j_sum = j_ff + rd0_ff + ((ctrl.jadd == JADD_RD0_KEY) ? krd_ff : '0);

   always_comb begin
      case (ctrl.rd0_sel)
         RD0_INEXT: rd0_addr = i_ff + BYTE_W'(1);
         RD0_ICUR:  rd0_addr = i_ff;
         RD0_SUM:   rd0_addr = rd0_ff + rd1_ff;
         default:   rd0_addr = i_ff;
      endcase
   end

   assign rd0_en = (ctrl.rd0_sel != RD0_NONE);
   assign rd1_en = (ctrl.jadd != JADD_NONE);

   // single write port; the pending s[j] write of a data byte fills idle slots
   always_comb begin
      case (ctrl.wr_sel)
         WR_I_RD1: begin
            we    = 1'b1;
            waddr = i_ff;
            wdata = rd1_ff;
         end
         WR_J_SV: begin
            we    = 1'b1;
            waddr = j_ff;
            wdata = sv_ff;
         end
         default: begin
            we    = fin_go;
            waddr = j_ff;
            wdata = sv_ff;
         end
      endcase
   end

   // entries not yet written since the last identity load read as their index
   always_comb begin
      valid_in = valid_ff;
      if (we) begin
         valid_in[waddr] = 1'b1;
      end
      if (ctrl.clr_valid) begin
         valid_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         perm_mem[waddr] <= wdata;
      end
   end

   // write-first reads with registered data
   always_ff @(posedge clock) begin
      if (rd0_en) begin
         if (we && (waddr == rd0_addr)) begin
            rd0_ff <= wdata;
         end else if (valid_ff[rd0_addr]) begin
            rd0_ff <= perm_mem[rd0_addr];
         end else begin
            rd0_ff <= rd0_addr;
         end
      end
      if (rd1_en) begin
         if (we && (waddr == j_sum)) begin
            rd1_ff <= wdata;
         end else if (valid_ff[j_sum]) begin
            rd1_ff <= perm_mem[j_sum];
         end else begin
            rd1_ff <= j_sum;
         end
      end
   end

   // key store: a new key restarts at entry zero once a schedule has run
   assign eff_len  = done_ff ? '0 : len_ff;
   assign key_room = (eff_len < LEN_W'(MAX_KEY_BYTES));
   assign key_we   = acc.key && key_room;
   assign kidx_nxt = kidx_ff + LEN_W'(1);

   always_ff @(posedge clock) begin
      if (key_we) begin
         key_mem[eff_len[KEY_AW-1:0]] <= byte_in;
      end
      if (ctrl.key_rd) begin
         krd_ff <= key_mem[kidx_ff[KEY_AW-1:0]];
      end
   end

   always_comb begin
      len_in  = len_ff;
      done_in = done_ff;
      if (acc.key) begin
         len_in  = eff_len + (key_room ? LEN_W'(1) : LEN_W'(0));
         done_in = 1'b0;
      end else if (ctrl.set_done) begin
         done_in = 1'b1;
      end
   end

   always_comb begin
      kidx_in = kidx_ff;
      if (ctrl.key_clr) begin
         kidx_in = '0;
      end else if (ctrl.key_adv) begin
         kidx_in = (kidx_nxt == len_ff) ? '0 : kidx_nxt;
      end
   end

   always_comb begin
      case (ctrl.i_op)
         IOP_INC: i_in = i_ff + BYTE_W'(1);
         IOP_CLR: i_in = '0;
         default: i_in = i_ff;
      endcase
   end

   always_comb begin
      if (ctrl.j_clr) begin
         j_in = '0;
      end else if (ctrl.jadd != JADD_NONE) begin
         j_in = j_sum;
      end else begin
         j_in = j_ff;
      end
   end

   assign sv_in  = ctrl.save ? rd0_ff : sv_ff;
   assign din_in = acc.data ? byte_in : din_ff;

   always_comb begin
      if (ctrl.arm_fin) begin
         fin_in = 1'b1;
      end else if (fin_go) begin
         fin_in = 1'b0;
      end else begin
         fin_in = fin_ff;
      end
   end

   // keystream index lands on s[j] whose write is still pending: use saved s[i]
   assign t_addr   = sv_ff + rd1_ff;
   assign ks_byte  = (t_addr == j_ff) ? sv_ff : rd0_ff;
   assign out_byte = din_ff ^ ks_byte;
   assign out_load = fin_go;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         i_ff     <= '0;
         j_ff     <= '0;
         len_ff   <= '0;
         kidx_ff  <= '0;
         done_ff  <= 1'b0;
         fin_ff   <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         i_ff     <= i_in;
         j_ff     <= j_in;
         len_ff   <= len_in;
         kidx_ff  <= kidx_in;
         done_ff  <= done_in;
         fin_ff   <= fin_in;
      end
   end

   always_ff @(posedge clock) begin
      sv_ff  <= sv_in;
      din_ff <= din_in;
   end

   `ASSERT_IMPL(a_sched_wraps, clock, reset, ctrl.set_done, i_ff == '0, "i not wrapped")

endmodule

// File: test/tb_top.sv
// self-checking testbench for rc4_stream_cipher: directed table, then random key and data traffic
// predicts every byte_out with its own rc4 shadow state
// depends on rc4_pkg, rc4_chan_if and rc4_stream_cipher
`timescale 1ns / 1ps

module tb_top import rc4_pkg::*;;

   // transaction kinds on req_chan
   localparam logic KIND_KEY  = 1'b0;
   localparam logic KIND_DATA = 1'b1;

   localparam int N_DIRECTED   = 23;
   localparam int ITEM_TARGET  = 1950;
   // the last stretch of the run goes without idle cycles
   localparam int QUIET_TAIL   = 200;
   // long receiver hold-off, well below the watchdog
   localparam int HOLD_CYCLES  = 300;
   // a whole key schedule keeps both channels quiet, so the limit lies well above it
   localparam int QUIET_LIMIT  = 5000;
   localparam int DRAIN_CYCLES = 20;

   typedef logic [BYTE_W-1:0] octet_type;

   // one row of the directed table; want is only used when typed is set
   typedef struct packed {
      logic      kind;
      octet_type value;
      logic      last;
      logic      typed;
      octet_type want;
   } vector_type;

   logic clock;
   logic reset;

   rc4_req_if req_chan ();
   rc4_rsp_if rsp_chan ();

   rc4_stream_cipher i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // shadow copy of the cipher state
   octet_type sbox [TABLE_SIZE];
   octet_type key_bytes [KEY_BYTES_DFLT];
   int        key_count;
   octet_type idx_i;
   octet_type idx_j;
   bit        key_set;

   // cipher bytes still owed by the block, oldest first
   octet_type cipher_q [$];

   int        errors     = 0;
   int        quiet      = 0;
   int        items_sent = 0;
   bit        idle_on    = 1'b0;
   bit        hold_request = 1'b0;
   logic      cur_typed  = 1'b0;
   octet_type cur_want   = '0;

   // directed rows: reset state first, then the extremes, a key split by data,
   // key_last on data, a new key after a finished schedule and a known vector
   vector_type directed [N_DIRECTED] = '{
      // identity table after reset: keystream starts 02, 05
      '{KIND_DATA, 8'h00, 1'b0, 1'b1, 8'h02},
      '{KIND_DATA, 8'hff, 1'b0, 1'b1, 8'hfa},
      // key entry with a data transaction in the middle
      '{KIND_KEY,  8'hff, 1'b0, 1'b0, 8'h00},
      '{KIND_DATA, 8'h5a, 1'b0, 1'b0, 8'h00},
      '{KIND_KEY,  8'h00, 1'b0, 1'b0, 8'h00},
      '{KIND_KEY,  8'h80, 1'b1, 1'b0, 8'h00},
      '{KIND_DATA, 8'h00, 1'b0, 1'b0, 8'h00},
      '{KIND_DATA, 8'hff, 1'b0, 1'b0, 8'h00},
      // key_last means nothing on a data byte
      '{KIND_DATA, 8'h55, 1'b1, 1'b0, 8'h00},
      // new one-byte key after a finished schedule
      '{KIND_KEY,  8'h01, 1'b1, 1'b0, 8'h00},
      '{KIND_DATA, 8'haa, 1'b0, 1'b0, 8'h00},
      '{KIND_DATA, 8'h0f, 1'b0, 1'b0, 8'h00},
      '{KIND_KEY,  8'h00, 1'b1, 1'b0, 8'h00},
      '{KIND_DATA, 8'hf0, 1'b0, 1'b0, 8'h00},
      '{KIND_DATA, 8'h00, 1'b1, 1'b0, 8'h00},
      // key "Key", plaintext "Plain" gives bb f3 16 e8 d9
      '{KIND_KEY,  8'h4b, 1'b0, 1'b0, 8'h00},
      '{KIND_KEY,  8'h65, 1'b0, 1'b0, 8'h00},
      '{KIND_KEY,  8'h79, 1'b1, 1'b0, 8'h00},
      '{KIND_DATA, 8'h50, 1'b0, 1'b1, 8'hbb},
      '{KIND_DATA, 8'h6c, 1'b0, 1'b1, 8'hf3},
      '{KIND_DATA, 8'h61, 1'b0, 1'b1, 8'h16},
      '{KIND_DATA, 8'h69, 1'b0, 1'b1, 8'he8},
      '{KIND_DATA, 8'h6e, 1'b0, 1'b1, 8'hd9}
   };

   // ------------------------------------------------------------------
   // cipher prediction
   // ------------------------------------------------------------------

   task automatic load_identity();
      for (int n = 0; n < TABLE_SIZE; n++) begin
         sbox[n] = octet_type'(n);
      end
   endtask

   // 256 swaps driven by the stored key bytes, taken cyclically
   task automatic run_key_schedule();
      octet_type acc;
      octet_type t;
      int        len;
      acc = '0;
      len = (key_count == 0) ? 1 : key_count;
      load_identity();
      for (int n = 0; n < TABLE_SIZE; n++) begin
         // 8-bit context, so the sum wraps like the j index
         acc       = acc + sbox[n] + key_bytes[n % len];
         t         = sbox[n];
         sbox[n]   = sbox[acc];
         sbox[acc] = t;
      end
      idx_i   = '0;
      idx_j   = '0;
      key_set = 1'b1;
   endtask

   // one generator step: advance i and j, swap, read the keystream byte
   function automatic octet_type keystream_byte();
      octet_type t;
      idx_i       = idx_i + 8'd1;
      idx_j       = idx_j + sbox[idx_i];
      t           = sbox[idx_i];
      sbox[idx_i] = sbox[idx_j];
      sbox[idx_j] = t;
      return sbox[octet_type'(sbox[idx_i] + sbox[idx_j])];
   endfunction

   task automatic absorb_key_byte(input octet_type value, input logic last);
      // a key byte after a finished schedule opens a new key
      if (key_set) begin
         key_count = 0;
         key_set   = 1'b0;
      end
      // bytes past the key store are dropped
      if (key_count < KEY_BYTES_DFLT) begin
         key_bytes[key_count] = value;
         key_count++;
      end
      if (last) begin
         run_key_schedule();
      end
   endtask

   // ------------------------------------------------------------------
   // clock
   // ------------------------------------------------------------------

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // channel monitor: both handshakes sampled at the rising edge
   // ------------------------------------------------------------------

   always @(posedge clock) begin : watch_channels
      octet_type want;
      bit        moved;
      if (!reset) begin
         moved = 1'b0;
         // result side first: its transaction is always older than a new request
         if (rsp_chan.valid && rsp_chan.ready) begin
            moved = 1'b1;
            if (cipher_q.size() == 0) begin
               errors++;
               $display("%0t: byte_out with nothing expected: expected none, actual %02h",
                        $time, rsp_chan.byte_out);
            end else begin
               want = cipher_q.pop_front();
               if (rsp_chan.byte_out !== want) begin
                  errors++;
                  $display("%0t: byte_out mismatch: expected %02h, actual %02h",
                           $time, want, rsp_chan.byte_out);
               end
            end
         end
         if (req_chan.valid && req_chan.ready) begin
            moved = 1'b1;
            if (req_chan.kind == KIND_DATA) begin
               want = req_chan.byte_in ^ keystream_byte();
               // a typed row overrides the shadow state's answer
               if (cur_typed) begin
                  want = cur_want;
               end
               cipher_q.push_back(want);
            end else begin
               absorb_key_byte(req_chan.byte_in, req_chan.key_last);
            end
         end
         quiet = moved ? 0 : quiet + 1;
      end
   end

   // ------------------------------------------------------------------
   // watchdog: too long without any transaction on either channel
   // ------------------------------------------------------------------

   initial begin : watchdog
      wait (reset === 1'b0);
      while (quiet < QUIET_LIMIT) @(posedge clock);
      $display("** rc4_stream_cipher: FAILED **");
      $finish;
   end

   // ------------------------------------------------------------------
   // result receiver: random short stalls, one long hold-off on request
   // ------------------------------------------------------------------

   initial begin : rsp_receiver
      wait (reset === 1'b0);
      forever begin
         @(negedge clock);
         if (hold_request) begin
            // long hold-off so the block fills and stalls req_chan
            hold_request = 1'b0;
            rsp_chan.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            rsp_chan.ready <= 1'b1;
         end else if (idle_on && $urandom_range(0, 3) == 0) begin
            rsp_chan.ready <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge clock);
            rsp_chan.ready <= 1'b1;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   // ------------------------------------------------------------------
   // request driver: called just after a falling edge, returns just after
   // the falling edge that follows the accepting rising edge
   // ------------------------------------------------------------------

   task automatic send(input logic kind, input octet_type value, input logic last,
                       input logic typed, input octet_type want);
      // optional idle burst before the transaction
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(negedge clock);
      end
      req_chan.valid    <= 1'b1;
      req_chan.kind     <= kind;
      req_chan.byte_in  <= value;
      req_chan.key_last <= last;
      cur_typed = typed;
      cur_want  = want;
      do @(posedge clock); while (!req_chan.ready);
      items_sent++;
      @(negedge clock);
   endtask

   // ------------------------------------------------------------------
   // stimulus
   // ------------------------------------------------------------------

   initial begin : stimulus
      int seq_n;
      int len;
      int pick;

      // every input known from time zero
      reset             = 1'b1;
      req_chan.valid    = 1'b0;
      req_chan.kind     = KIND_KEY;
      req_chan.byte_in  = '0;
      req_chan.key_last = 1'b0;
      rsp_chan.ready    = 1'b0;

      // shadow state after reset
      load_identity();
      for (int n = 0; n < KEY_BYTES_DFLT; n++) begin
         key_bytes[n] = '0;
      end
      key_count = 0;
      idx_i     = '0;
      idx_j     = '0;
      key_set   = 1'b0;

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed table
      idle_on = 1'b1;
      for (int r = 0; r < N_DIRECTED; r++) begin
         send(directed[r].kind, directed[r].value, directed[r].last,
              directed[r].typed, directed[r].want);
      end

      // random traffic, mostly whole keys followed by runs of data
      seq_n = 0;
      while (items_sent < ITEM_TARGET) begin
         // idling switched per sequence, and off for the tail of the run
         idle_on = (items_sent < ITEM_TARGET - QUIET_TAIL) && ($urandom_range(0, 3) != 0);
         pick    = $urandom_range(0, 9);
         if (seq_n == 8) begin
            // receiver holds off while data keeps coming
            hold_request = 1'b1;
            repeat (40) begin
               send(KIND_DATA, octet_type'($urandom_range(0, 255)),
                    1'($urandom_range(0, 1)), 1'b0, '0);
            end
         end else if (seq_n == 16) begin
            // sender pauses until every owed byte has come back
            req_chan.valid <= 1'b0;
            while (cipher_q.size() != 0) @(posedge clock);
            @(negedge clock);
         end else if (pick < 7 || seq_n == 4 || seq_n == 12) begin
            // overlong key once, a full-size key once, short keys otherwise
            if (seq_n == 4) begin
               len = $urandom_range(KEY_BYTES_DFLT + 1, KEY_BYTES_DFLT + 44);
            end else if (seq_n == 12) begin
               len = KEY_BYTES_DFLT;
            end else if ($urandom_range(0, 4) == 0) begin
               len = $urandom_range(17, 64);
            end else begin
               len = $urandom_range(1, 16);
            end
            for (int n = 1; n <= len; n++) begin
               // now and then a data byte lands inside key entry
               if ($urandom_range(0, 7) == 0) begin
                  send(KIND_DATA, octet_type'($urandom_range(0, 255)), 1'b0, 1'b0, '0);
               end
               send(KIND_KEY, octet_type'($urandom_range(0, 255)), n == len, 1'b0, '0);
            end
            repeat ($urandom_range(8, 60)) begin
               send(KIND_DATA, octet_type'($urandom_range(0, 255)), 1'b0, 1'b0, '0);
            end
         end else if (pick < 9) begin
            // noise: any kind, key_last now and then
            repeat ($urandom_range(1, 6)) begin
               send(1'($urandom_range(0, 1)), octet_type'($urandom_range(0, 255)),
                    $urandom_range(0, 7) == 0, 1'b0, '0);
            end
         end else begin
            // data run with a stray key_last bit
            repeat ($urandom_range(1, 20)) begin
               send(KIND_DATA, octet_type'($urandom_range(0, 255)),
                    1'($urandom_range(0, 1)), 1'b0, '0);
            end
         end
         seq_n++;
      end

      // wind down: no more transactions, collect what is owed, then a short drain
      req_chan.valid <= 1'b0;
      while (cipher_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (errors == 0) begin
         $display("** rc4_stream_cipher: PASSED **");
      end else begin
         $display("** rc4_stream_cipher: FAILED **");
      end
      $finish;
   end

endmodule

// File: files.f
+incdir+rtl
rtl/rc4_pkg.sv
rtl/rc4_chan_if.sv
rtl/rc4_useq.sv
rtl/rc4_datapath.sv
rtl/rc4_stream_cipher.sv
test/tb_top.sv
